### hdl/ldrt_pkg.sv
package ldrt_pkg;

    localparam int CHAR_W      = 7;
    localparam int CHAR_COUNT  = 1 << CHAR_W;
    localparam int LEN_W       = 17;

    localparam int ALPHABET_SIZE_DEF = 128;
    localparam int STRING_MAX_DEF    = 65536;

endpackage

### hdl/ldrt_if.sv
interface ldrt_in_if import ldrt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface ldrt_out_if import ldrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] best_length;
    logic [LEN_W-1:0] current_length;
    logic             is_final;
    logic             overflow;

    modport source (output valid, output best_length, output current_length,
                    output is_final, output overflow, input ready);
    modport sink   (input valid, input best_length, input current_length,
                    input is_final, input overflow, output ready);
endinterface

### hdl/ldrt_ram.sv
module ldrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/longest_distinct_run_tracker_top.sv
// Longest repeat-free run tracker. Feed a string one character per item;
// every item returns one result with the run length ending at that character
// and the best run so far. An item flagged end_of_string yields the final
// answer and clears string state, so the next item starts a new string. Items
// are taken one per cycle unless the output stalls; each result is registered
// as it leaves stage 2: the last-position table is a RAM with a registered
// read, read as an item is taken and written back as it leaves, with a bypass
// for a character that repeats at once. A result that is not taken holds the
// item behind it. Characters past STRING_MAX are ignored and raise the
// overflow flag. No clearing pass is needed after reset.
module longest_distinct_run_tracker_top import ldrt_pkg::*; #(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int STRING_MAX    = STRING_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ldrt_in_if.sink     i_in,
    ldrt_out_if.source  o_out
);

    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam int POS_W = $clog2(STRING_MAX);
    localparam int CNT_W = $clog2(STRING_MAX + 1);

    // character code folded into the alphabet
    logic [IDX_W-1:0] w_fold [CHAR_COUNT];

    for (genvar g = 0; g < CHAR_COUNT; g++) begin : g_fold
        assign w_fold[g] = IDX_W'(g % ALPHABET_SIZE);
    end

    // stage 2: item waiting on its table read
    logic             r_s2_vld;
    logic [IDX_W-1:0] r_s2_idx;
    logic             r_s2_last;

    // string state
    logic [ALPHABET_SIZE-1:0] r_seen;
    logic [CNT_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_win;
    logic [CNT_W-1:0]         r_best;
    logic                     r_ovf;

    // last table write, for a read issued at the same edge
    logic             r_fwd_vld;
    logic [IDX_W-1:0] r_fwd_idx;
    logic [POS_W-1:0] r_fwd_pos;

    // output register
    logic             r_out_vld;
    logic [LEN_W-1:0] r_out_best;
    logic [LEN_W-1:0] r_out_cur;
    logic             r_out_final;
    logic             r_out_ovf;

    logic             w_out_free;
    logic             w_s2_go;
    logic             w_in_fire;
    logic [IDX_W-1:0] w_in_idx;
    logic [POS_W-1:0] w_ram_pos;
    logic [POS_W-1:0] w_last_pos;
    logic             w_full;
    logic             w_hit;
    logic [CNT_W-1:0] n_pos;
    logic [CNT_W-1:0] n_win;
    logic [CNT_W-1:0] n_best;
    logic [CNT_W-1:0] w_run;
    logic             n_ovf;
    logic             w_we;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_s2_go    = r_s2_vld && w_out_free;
    assign i_in.ready = !r_s2_vld || w_out_free;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_in_idx   = w_fold[i_in.char_code];

    ldrt_ram #(
        .WIDTH (POS_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_last_pos (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s2_idx),
        .i_wdata (r_pos[POS_W-1:0]),
        .i_re    (w_in_fire),
        .i_raddr (w_in_idx),
        .o_rdata (w_ram_pos)
    );

    always_comb begin
        w_last_pos = (r_fwd_vld && r_fwd_idx == r_s2_idx) ? r_fwd_pos : w_ram_pos;
        w_full     = r_pos >= CNT_W'(STRING_MAX);
        w_hit      = r_seen[r_s2_idx] && (CNT_W'(w_last_pos) >= r_win);
        n_pos      = r_pos;
        n_win      = r_win;
        n_best     = r_best;
        n_ovf      = r_ovf;
        if (w_full) begin
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
            if (w_hit) begin
                n_win = CNT_W'(w_last_pos) + 1'b1;
            end
        end
        w_run = n_pos - n_win;
        if (w_run > r_best) begin
            n_best = w_run;
        end
        w_we = w_s2_go && !w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_seen    <= '0;
            r_pos     <= '0;
            r_win     <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_s2_vld <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_vld <= 1'b0;
            end

            if (w_s2_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            if (w_we) begin
                r_fwd_vld <= 1'b1;
            end

            if (w_s2_go) begin
                if (r_s2_last) begin
                    // string done: start afresh
                    r_seen <= '0;
                    r_pos  <= '0;
                    r_win  <= '0;
                    r_best <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    if (!w_full) begin
                        r_seen[r_s2_idx] <= 1'b1;
                    end
                    r_pos  <= n_pos;
                    r_win  <= n_win;
                    r_best <= n_best;
                    r_ovf  <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s2_idx  <= w_in_idx;
            r_s2_last <= i_in.end_of_string;
        end
        if (w_we) begin
            r_fwd_idx <= r_s2_idx;
            r_fwd_pos <= r_pos[POS_W-1:0];
        end
        if (w_s2_go) begin
            r_out_best  <= LEN_W'(n_best);
            r_out_cur   <= LEN_W'(w_run);
            r_out_final <= r_s2_last;
            r_out_ovf   <= n_ovf;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.best_length    = r_out_best;
    assign o_out.current_length = r_out_cur;
    assign o_out.is_final       = r_out_final;
    assign o_out.overflow       = r_out_ovf;

endmodule

### test/longest_distinct_run_tracker_top_tb.sv
module longest_distinct_run_tracker_top_tb;
    import ldrt_pkg::*;

    localparam int ALPHA        = ALPHABET_SIZE_DEF;
    localparam int STR_MAX      = STRING_MAX_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 240;
    localparam int IDLE_PCT     = 11;

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic [LEN_W-1:0] current_length;
        logic             is_final;
        logic             overflow;
    } run_result_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              typed;
        run_result_t       want;
    } stim_row_t;

    localparam run_result_t NO_RESULT = '0;

    logic i_clk;
    logic i_rst_n;

    ldrt_in_if  in_bus ();
    ldrt_out_if out_bus ();

    longest_distinct_run_tracker_top #(
        .ALPHABET_SIZE (ALPHA),
        .STRING_MAX    (STR_MAX)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    // Tracker state mirrored from the block
    bit          char_seen     [ALPHA];
    int unsigned char_last_pos [ALPHA];
    int unsigned str_pos;
    int unsigned win_start;
    int unsigned best_run;
    bit          ovf_seen;

    run_result_t pending_results [$];
    logic        row_typed;
    run_result_t row_want;
    logic        steady;
    int          fail_count;
    int          cycle_count;

    // Rows with a typed result are checked against it; the rest against the predictor
    stim_row_t directed_rows [20] = '{
        '{7'd97,  1'b0, 1'b1, '{17'd1, 17'd1, 1'b0, 1'b0}},
        '{7'd0,   1'b0, 1'b1, '{17'd2, 17'd2, 1'b0, 1'b0}},  // code zero is ordinary
        '{7'd127, 1'b0, 1'b1, '{17'd3, 17'd3, 1'b0, 1'b0}},
        '{7'd97,  1'b0, 1'b0, NO_RESULT},                     // repeat inside the window
        '{7'd127, 1'b0, 1'b0, NO_RESULT},
        '{7'd127, 1'b0, 1'b0, NO_RESULT},                     // back-to-back repeat
        '{7'd0,   1'b0, 1'b0, NO_RESULT},
        '{7'd85,  1'b0, 1'b0, NO_RESULT},
        '{7'd42,  1'b1, 1'b0, NO_RESULT},
        '{7'd5,   1'b1, 1'b1, '{17'd1, 17'd1, 1'b1, 1'b0}},  // single-character string
        '{7'd5,   1'b1, 1'b1, '{17'd1, 17'd1, 1'b1, 1'b0}},  // seen marks must be clear
        '{7'd98,  1'b0, 1'b1, '{17'd1, 17'd1, 1'b0, 1'b0}},
        '{7'd99,  1'b0, 1'b1, '{17'd2, 17'd2, 1'b0, 1'b0}},
        '{7'd99,  1'b0, 1'b0, NO_RESULT},
        '{7'd98,  1'b0, 1'b0, NO_RESULT},                     // repeat left of the window
        '{7'd100, 1'b1, 1'b0, NO_RESULT},
        '{7'd127, 1'b1, 1'b1, '{17'd1, 17'd1, 1'b1, 1'b0}},
        '{7'd0,   1'b1, 1'b1, '{17'd1, 17'd1, 1'b1, 1'b0}},
        '{7'd64,  1'b0, 1'b0, NO_RESULT},
        '{7'd63,  1'b1, 1'b0, NO_RESULT}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_tracker();
        foreach (char_seen[k]) begin
            char_seen[k]     = 1'b0;
            char_last_pos[k] = 0;
        end
        str_pos   = 0;
        win_start = 0;
        best_run  = 0;
        ovf_seen  = 1'b0;
    endfunction

    function automatic run_result_t advance_tracker(input logic [CHAR_W-1:0] code,
                                                    input logic last);
        int unsigned slot;
        run_result_t res;
        if (str_pos >= STR_MAX) begin
            ovf_seen = 1'b1;
        end else begin
            slot = int'(code) % ALPHA;
            if (char_seen[slot] && char_last_pos[slot] >= win_start)
                win_start = char_last_pos[slot] + 1;
            char_last_pos[slot] = str_pos;
            char_seen[slot]     = 1'b1;
            str_pos++;
            if (str_pos - win_start > best_run)
                best_run = str_pos - win_start;
        end
        res.best_length    = LEN_W'(best_run);
        res.current_length = LEN_W'(str_pos - win_start);
        res.is_final       = last;
        res.overflow       = ovf_seen;
        if (last)
            clear_tracker();
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic last,
                             input logic typed, input run_result_t want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.char_code     <= code;
        in_bus.end_of_string <= last;
        row_typed            <= typed;
        row_want             <= want;
        do @(posedge i_clk); while (!in_bus.ready);
        @(negedge i_clk);
    endtask

    // Cycle through the whole alphabet so the best run reaches its ceiling
    task automatic send_long_string(input int length);
        logic [CHAR_W-1:0] code;
        for (int i = 0; i < length; i++) begin
            code = CHAR_W'(i);
            send_char(code, i == length - 1, 1'b0, NO_RESULT);
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n)
            out_bus.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check results before taking in the item of this edge
    always @(posedge i_clk) begin
        run_result_t got;
        run_result_t want;
        run_result_t predicted;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                got.best_length    = out_bus.best_length;
                got.current_length = out_bus.current_length;
                got.is_final       = out_bus.is_final;
                got.overflow       = out_bus.overflow;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: best %0d cur %0d final %0b ovf %0b",
                                 got.best_length, got.current_length,
                                 got.is_final, got.overflow);
                end else begin
                    want = pending_results.pop_front();
                    if (got.best_length !== want.best_length
                        || got.current_length !== want.current_length
                        || got.is_final !== want.is_final
                        || got.overflow !== want.overflow) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result mismatch: want best %0d cur %0d final %0b ",
                                      "ovf %0b, got best %0d cur %0d final %0b ovf %0b"},
                                     want.best_length, want.current_length,
                                     want.is_final, want.overflow,
                                     got.best_length, got.current_length,
                                     got.is_final, got.overflow);
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                predicted = advance_tracker(in_bus.char_code, in_bus.end_of_string);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    initial begin
        int                sent;
        int                len;
        logic [CHAR_W-1:0] mask;
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] code;

        in_bus.valid         = 1'b0;
        in_bus.char_code     = '0;
        in_bus.end_of_string = 1'b0;
        out_bus.ready        = 1'b0;
        row_typed            = 1'b0;
        row_want             = NO_RESULT;
        steady               = 1'b0;
        fail_count           = 0;
        cycle_count          = 0;
        i_rst_n              = 1'b0;
        clear_tracker();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_char(directed_rows[r].code, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].want);

        // Run the alphabet twice in one string
        send_long_string(2 * CHAR_COUNT);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                              : $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       mask = 7'h01;
                1:       mask = 7'h07;
                2:       mask = 7'h1f;
                default: mask = 7'h7f;
            endcase
            base = CHAR_W'($urandom);
            for (int i = 0; i < len; i++) begin
                steady = sent >= 60 && sent < 180;
                code   = base ^ (CHAR_W'($urandom) & mask);
                send_char(code, i == len - 1, 1'b0, NO_RESULT);
                sent++;
            end
        end
        steady = 1'b0;
        in_bus.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
